// ===== hw/rtl/dcrc_pkg.sv =====
`default_nettype none

package dcrc_pkg;

    // Bus access type
    typedef enum logic {
        KIND_READ  = 1'b0,
        KIND_WRITE = 1'b1
    } t_kind;

    // Register selects
    typedef enum logic [1:0] {
        REG_CSR = 2'd0,
        REG_BA  = 2'd1,
        REG_DA  = 2'd2,
        REG_MP  = 2'd3
    } t_reg_sel;

    // Function codes in CSR bits 3..1; codes 1 and 7 are unused
    typedef enum logic [2:0] {
        CMD_NOP         = 3'd0,
        CMD_GET_STATUS  = 3'd2,
        CMD_SEEK        = 3'd3,
        CMD_READ_HEADER = 3'd4,
        CMD_WRITE       = 3'd5,
        CMD_READ        = 3'd6
    } t_cmd;

    localparam logic [15:0] CSR_WRITE_MASK  = 16'h03FE;
    localparam logic [15:0] CSR_DRIVE_RDY   = 16'h0001;
    localparam logic [15:0] CSR_CTRL_RDY    = 16'h0080;
    localparam logic [15:0] CSR_ERR_BITS    = 16'h9400;
    localparam logic [15:0] GET_STATUS_WORD = 16'h009D;
    localparam logic [15:0] HEADER_MARK     = 16'hBABE;
    localparam logic [15:0] BA_MASK         = 16'hFFFE;
    localparam logic [15:0] DA_TRACK_MASK   = 16'hFFC0;

    // One bus access
    typedef struct packed {
        logic        kind;
        logic [1:0]  reg_select;
        logic [15:0] write_data;
    } t_in_item;

    // One result
    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_request;
        logic        transfer_valid;
        logic        transfer_write;
        logic [15:0] disk_block;
        logic [15:0] memory_address;
        logic [13:0] transfer_bytes;
    } t_out_item;

    // Transfer geometry worked out from the disk address and word count
    typedef struct packed {
        logic        err;
        logic [15:0] bytes;
        logic [5:0]  sector_new;
        logic [15:0] disk_block;
    } t_xfer_res;

endpackage

`default_nettype wire

// ===== hw/rtl/dcrc_cfg.sv =====
`default_nettype none

module dcrc_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic             o_image_loaded
);

    localparam logic CFG_IDX_IMAGE_LOADED = 1'b0;

    logic r_image_loaded;
    logic w_sel_image;

    assign w_sel_image = (paddr[2] == CFG_IDX_IMAGE_LOADED);

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_loaded <= 1'b0;
        end else if (psel && penable && pwrite && w_sel_image) begin
            r_image_loaded <= pwdata[0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (w_sel_image) begin
            prdata = {31'b0, r_image_loaded};
        end
    end

    assign pready         = 1'b1;
    assign o_image_loaded = r_image_loaded;

endmodule

`default_nettype wire

// ===== hw/rtl/dcrc_xfer.sv =====
`default_nettype none

module dcrc_xfer #(
    parameter int unsigned SECTORS_PER_TRACK = 40,
    parameter int unsigned SECTOR_BYTES      = 256
) (
    input  wire logic [15:0]         i_disk_address,
    input  wire logic [15:0]         i_multipurpose,
    output dcrc_pkg::t_xfer_res      o_res
);

    logic [5:0]                 w_sec;
    logic [9:0]                 w_track;
    logic [15:0]                w_words;
    logic [16:0]                w_bytes_req;
    logic                       w_beyond;
    logic [5:0]                 w_room;
    logic [16:0]                w_room_bytes;
    logic                       w_trunc;
    logic [SECTORS_PER_TRACK:0] w_thermo;
    logic [5:0]                 w_nsec;

    always_comb begin
        w_sec       = i_disk_address[5:0];
        w_track     = i_disk_address[15:6];
        // MP holds the negated word count
        w_words     = 16'd0 - i_multipurpose;
        w_bytes_req = {w_words, 1'b0};

        // Room left on the track
        w_beyond     = ({1'b0, w_sec} > 7'(SECTORS_PER_TRACK));
        w_room       = w_beyond ? 6'd0 : (6'(SECTORS_PER_TRACK) - w_sec);
        w_room_bytes = 17'(17'(SECTOR_BYTES) * w_room);
        w_trunc      = w_beyond || (w_bytes_req > w_room_bytes);

        // Sector count: thermometer of byte thresholds, decoded at its edge
        w_thermo[SECTORS_PER_TRACK] = 1'b0;
        for (int k = 0; k < SECTORS_PER_TRACK; k++) begin
            w_thermo[k] = (w_bytes_req > 17'(SECTOR_BYTES * k));
        end
        w_nsec = '0;
        for (int k = 0; k < SECTORS_PER_TRACK; k++) begin
            if (w_thermo[k] && !w_thermo[k+1]) begin
                w_nsec = w_nsec | 6'(k + 1);
            end
        end

        o_res.err   = w_trunc;
        o_res.bytes = w_trunc ? w_room_bytes[15:0] : w_bytes_req[15:0];
        if (!w_trunc) begin
            o_res.sector_new = w_sec + w_nsec;
        end else if (w_beyond) begin
            o_res.sector_new = w_sec;
        end else begin
            o_res.sector_new = 6'(SECTORS_PER_TRACK);
        end
        o_res.disk_block = 16'({6'b0, w_track} * 16'(SECTORS_PER_TRACK)) + {10'b0, w_sec};
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dcrc_core.sv =====
`default_nettype none

module dcrc_core #(
    parameter int unsigned SECTORS_PER_TRACK = 40,
    parameter int unsigned CYLINDER_COUNT    = 512,
    parameter int unsigned SECTOR_BYTES      = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire dcrc_pkg::t_in_item i_item,
    input  wire logic               i_image_loaded,
    output dcrc_pkg::t_out_item     o_result
);

    logic [15:0] r_status, n_status;
    logic [15:0] r_ba, n_ba;
    logic [15:0] r_da, n_da;
    logic [15:0] r_mp, n_mp;
    logic        r_ie, n_ie;
    logic        r_head, n_head;
    logic [8:0]  r_cyl, n_cyl;
    logic [5:0]  r_sector, n_sector;
    logic [15:0] r_hq0, n_hq0;
    logic [15:0] r_hq1, n_hq1;
    logic [1:0]  r_qcount, n_qcount;

    dcrc_pkg::t_xfer_res w_xfer;
    logic [8:0]          w_move;
    logic [9:0]          w_up_sum;
    logic [8:0]          w_seek_cyl;
    logic [15:0]         w_val;
    dcrc_pkg::t_cmd      w_cmd;

    dcrc_xfer #(
        .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
        .SECTOR_BYTES      (SECTOR_BYTES)
    ) u_xfer (
        .i_disk_address (r_da),
        .i_multipurpose (r_mp),
        .o_res          (w_xfer)
    );

    assign w_val = i_item.write_data;
    assign w_cmd = dcrc_pkg::t_cmd'(w_val[3:1]);

    // Seek target, saturating at both ends
    always_comb begin
        w_move   = r_da[15:7];
        w_up_sum = {1'b0, r_cyl} + {1'b0, w_move};
        if (r_da[2]) begin
            w_seek_cyl = (w_up_sum >= 10'(CYLINDER_COUNT)) ? 9'(CYLINDER_COUNT - 1)
                                                           : w_up_sum[8:0];
        end else begin
            w_seek_cyl = (w_move > r_cyl) ? 9'd0 : (r_cyl - w_move);
        end
    end

    // Access decode and command execution
    always_comb begin
        n_status = r_status;
        n_ba     = r_ba;
        n_da     = r_da;
        n_mp     = r_mp;
        n_ie     = r_ie;
        n_head   = r_head;
        n_cyl    = r_cyl;
        n_sector = r_sector;
        n_hq0    = r_hq0;
        n_hq1    = r_hq1;
        n_qcount = r_qcount;
        o_result = '0;

        if (i_item.kind == dcrc_pkg::KIND_READ) begin
            case (dcrc_pkg::t_reg_sel'(i_item.reg_select))
                dcrc_pkg::REG_CSR: o_result.read_data = r_status | dcrc_pkg::CSR_DRIVE_RDY;
                dcrc_pkg::REG_BA:  o_result.read_data = r_ba;
                dcrc_pkg::REG_DA:  o_result.read_data = r_da;
                dcrc_pkg::REG_MP: begin
                    o_result.read_data = r_mp;
                    // header queue pops on each MP read
                    if (r_qcount != 2'd0) begin
                        n_mp     = r_hq0;
                        n_hq0    = r_hq1;
                        n_qcount = r_qcount - 2'd1;
                    end
                end
                default: o_result.read_data = '0;
            endcase
        end else begin
            case (dcrc_pkg::t_reg_sel'(i_item.reg_select))
                dcrc_pkg::REG_CSR: begin
                    n_status = w_val & dcrc_pkg::CSR_WRITE_MASK;
                    n_ie     = w_val[6];
                    if (!w_val[7]) begin
                        case (w_cmd)
                            dcrc_pkg::CMD_WRITE, dcrc_pkg::CMD_READ: begin
                                if (i_image_loaded) begin
                                    o_result.transfer_valid = 1'b1;
                                    o_result.transfer_write = (w_cmd == dcrc_pkg::CMD_WRITE);
                                    o_result.disk_block     = w_xfer.disk_block;
                                    o_result.memory_address = r_ba;
                                    o_result.transfer_bytes = w_xfer.bytes[13:0];
                                    o_result.irq_request    = w_val[6];
                                    n_ba     = r_ba + w_xfer.bytes;
                                    n_mp     = r_mp + {1'b0, w_xfer.bytes[15:1]};
                                    n_sector = w_xfer.sector_new;
                                    n_da     = (r_da & dcrc_pkg::DA_TRACK_MASK)
                                             | {10'b0, w_xfer.sector_new};
                                    if (w_xfer.err) begin
                                        n_status = n_status | dcrc_pkg::CSR_ERR_BITS;
                                    end
                                end
                            end
                            dcrc_pkg::CMD_GET_STATUS: begin
                                n_mp     = dcrc_pkg::GET_STATUS_WORD | {9'b0, r_head, 6'b0};
                                n_qcount = 2'd0;
                                o_result.irq_request = w_val[6];
                            end
                            dcrc_pkg::CMD_READ_HEADER: begin
                                n_mp     = {r_cyl, r_head, r_sector};
                                n_hq0    = '0;
                                n_hq1    = dcrc_pkg::HEADER_MARK;
                                n_qcount = 2'd2;
                                o_result.irq_request = w_val[6];
                            end
                            dcrc_pkg::CMD_SEEK: begin
                                n_head = r_da[4];
                                n_cyl  = w_seek_cyl;
                                o_result.irq_request = w_val[6];
                            end
                            dcrc_pkg::CMD_NOP: o_result.irq_request = w_val[6];
                            default:           o_result.irq_request = 1'b0;
                        endcase
                    end else begin
                        // no command: interrupt on enable rising
                        o_result.irq_request = !r_ie && w_val[6];
                    end
                    n_status = n_status | dcrc_pkg::CSR_CTRL_RDY;
                end
                dcrc_pkg::REG_BA: n_ba = w_val & dcrc_pkg::BA_MASK;
                dcrc_pkg::REG_DA: n_da = w_val;
                dcrc_pkg::REG_MP: n_mp = w_val;
                default:          n_mp = r_mp;
            endcase
        end
    end

    // Register state, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
            r_ba     <= '0;
            r_da     <= '0;
            r_mp     <= '0;
            r_ie     <= 1'b0;
            r_head   <= 1'b0;
            r_cyl    <= '0;
            r_sector <= '0;
            r_hq0    <= '0;
            r_hq1    <= '0;
            r_qcount <= '0;
        end else if (i_fire) begin
            r_status <= n_status;
            r_ba     <= n_ba;
            r_da     <= n_da;
            r_mp     <= n_mp;
            r_ie     <= n_ie;
            r_head   <= n_head;
            r_cyl    <= n_cyl;
            r_sector <= n_sector;
            r_hq0    <= n_hq0;
            r_hq1    <= n_hq1;
            r_qcount <= n_qcount;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/disk_cartridge_register_controller.sv =====
// Register front end of a cartridge disk controller. Each input item is one bus
// access (read or write) to CSR, BA, DA or MP; each gives exactly one result
// item holding the read data, the interrupt request and, for read/write
// commands, the transfer request (block, bus address, byte count). The block
// takes one item per clock cycle while its output is not stalled; an item
// lands in the input register, the register update and result are worked out
// from it combinationally, and the result is registered in the output register
// once that is free or draining. The rate is set by the register file update.
// The image_loaded bit is set through the APB port at address 0.
`default_nettype none

module disk_cartridge_register_controller #(
    parameter int unsigned SECTORS_PER_TRACK = 40,
    parameter int unsigned CYLINDER_COUNT    = 512,
    parameter int unsigned SECTOR_BYTES      = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire dcrc_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output dcrc_pkg::t_out_item      o_out_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    logic                r_in_vld;
    dcrc_pkg::t_in_item  r_in_item;
    logic                r_out_vld;
    dcrc_pkg::t_out_item r_out_item;
    dcrc_pkg::t_out_item w_result;
    logic                w_out_take;
    logic                w_fire;
    logic                w_image_loaded;

    dcrc_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_image_loaded (w_image_loaded)
    );

    dcrc_core #(
        .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
        .CYLINDER_COUNT    (CYLINDER_COUNT),
        .SECTOR_BYTES      (SECTOR_BYTES)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_item         (r_in_item),
        .i_image_loaded (w_image_loaded),
        .o_result       (w_result)
    );

    // Pipeline flow: output register frees or drains, input register moves on
    assign w_out_take = !r_out_vld || !i_out_stall;
    assign w_fire     = r_in_vld && w_out_take;
    assign o_in_stall = r_in_vld && !w_out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (w_out_take) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== hw/rtl/dcrc_checker.sv =====
`default_nettype none

module dcrc_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire dcrc_pkg::t_out_item o_out_item
);

    // Input only stalls behind a stalled, full output
    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the output can drain");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result item changed");

    // No transfer: the transfer fields are all zero
    a_no_xfer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.transfer_valid) |->
        (!o_out_item.transfer_write && o_out_item.disk_block == 16'd0 &&
         o_out_item.memory_address == 16'd0 && o_out_item.transfer_bytes == 14'd0))
        else $error("transfer fields set without a transfer");

    // A transfer comes from a CSR write: no read data, even address and count
    a_xfer_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.transfer_valid) |->
        (o_out_item.read_data == 16'd0 && !o_out_item.memory_address[0] &&
         !o_out_item.transfer_bytes[0]))
        else $error("malformed transfer item");

endmodule

bind disk_cartridge_register_controller dcrc_checker u_dcrc_checker (.*);

`default_nettype wire

// ===== tb/tb_disk_cartridge_register_controller.sv =====
`timescale 1ns / 100ps

module tb_disk_cartridge_register_controller;

    // Drive geometry as built
    localparam int unsigned TRACK_SECTORS = 40;
    localparam int unsigned CYLINDERS     = 512;
    localparam int unsigned BYTES_PER_SEC = 256;

    // APB map and CSR helpers
    localparam logic [2:0]  ADDR_IMAGE_LOADED = 3'd0;
    localparam logic [2:0]  CMD_SPARE_LO      = 3'd1;
    localparam logic [2:0]  CMD_SPARE_HI      = 3'd7;
    localparam logic [15:0] CSR_CODE_BITS     = 16'h00CE;
    localparam logic [15:0] CSR_LOW_BITS      = 16'h03FF;

    localparam int unsigned PHASE_ITEMS = 245;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    dcrc_pkg::t_in_item  in_item  = '0;
    logic                out_stall = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [2:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;

    logic                o_in_stall;
    logic                o_out_valid;
    dcrc_pkg::t_out_item o_out_item;
    logic [31:0]         prdata;
    logic                pready;

    disk_cartridge_register_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the controller registers
    logic        cfg_image = 1'b0;
    logic [15:0] st_csr    = '0;
    logic [15:0] st_ba     = '0;
    logic [15:0] st_da     = '0;
    logic [15:0] st_mp     = '0;
    logic        st_ie     = 1'b0;
    logic        st_head   = 1'b0;
    logic [8:0]  st_cyl    = '0;
    logic [5:0]  st_sector = '0;
    logic [15:0] hdr_words [2] = '{16'h0, 16'h0};
    logic [1:0]  hdr_count = '0;

    dcrc_pkg::t_in_item  bus_access_queue [$];
    dcrc_pkg::t_out_item bus_replies_due [$];
    int unsigned queued_total = 0;
    int unsigned fail_count = 0;
    bit          send_idle_on = 1'b0;
    bit          rcv_idle_on  = 1'b0;

    // Function code execution on a CSR write
    function automatic void run_disk_command(inout dcrc_pkg::t_out_item r, output logic irq);
        logic [2:0]  cmd;
        int unsigned sec;
        int unsigned trk;
        int unsigned words;
        int unsigned nbytes;
        int unsigned nsec;
        int unsigned move;
        int unsigned sum;
        cmd = st_csr[3:1];
        irq = 1'b0;
        case (cmd)
            dcrc_pkg::CMD_WRITE, dcrc_pkg::CMD_READ: begin
                if (cfg_image) begin
                    sec    = st_da[5:0];
                    trk    = st_da[15:6];
                    words  = (32'd65536 - st_mp) & 32'hFFFF;
                    nbytes = 2 * words;
                    nsec   = (nbytes + BYTES_PER_SEC - 1) / BYTES_PER_SEC;
                    // clip at end of track; sector past the track moves nothing
                    if (nsec + sec > TRACK_SECTORS) begin
                        if (sec > TRACK_SECTORS) begin
                            nbytes = 0;
                            nsec   = 0;
                        end else begin
                            nbytes = BYTES_PER_SEC * (TRACK_SECTORS - sec);
                            nsec   = TRACK_SECTORS - sec;
                        end
                        st_csr = st_csr | dcrc_pkg::CSR_ERR_BITS;
                    end
                    r.transfer_valid = 1'b1;
                    r.transfer_write = (cmd == dcrc_pkg::CMD_WRITE);
                    r.disk_block     = 16'(trk * TRACK_SECTORS + sec);
                    r.memory_address = st_ba;
                    r.transfer_bytes = 14'(nbytes);
                    st_ba     = st_ba + 16'(nbytes);
                    st_mp     = st_mp + 16'(nbytes >> 1);
                    st_sector = 6'(sec + nsec);
                    st_da     = (st_da & dcrc_pkg::DA_TRACK_MASK) | {10'b0, st_sector};
                    irq       = st_ie;
                end
            end
            dcrc_pkg::CMD_GET_STATUS: begin
                if (st_da[3])
                    st_csr = st_csr & CSR_LOW_BITS;
                st_mp     = dcrc_pkg::GET_STATUS_WORD | {9'b0, st_head, 6'b0};
                hdr_count = '0;
                irq       = st_ie;
            end
            dcrc_pkg::CMD_READ_HEADER: begin
                st_mp        = {st_cyl, st_head, st_sector};
                hdr_words[0] = 16'h0;
                hdr_words[1] = dcrc_pkg::HEADER_MARK;
                hdr_count    = 2'd2;
                irq          = st_ie;
            end
            dcrc_pkg::CMD_SEEK: begin
                move    = st_da[15:7];
                st_head = st_da[4];
                if (st_da[2]) begin
                    sum    = st_cyl + move;
                    st_cyl = (sum >= CYLINDERS) ? 9'(CYLINDERS - 1) : 9'(sum);
                end else begin
                    st_cyl = (move > st_cyl) ? 9'd0 : 9'(st_cyl - move);
                end
                irq = st_ie;
            end
            dcrc_pkg::CMD_NOP: irq = st_ie;
            default: irq = 1'b0;
        endcase
    endfunction

    // Expected reply for one bus access; updates the register mirror
    function automatic dcrc_pkg::t_out_item predict_bus_access(input dcrc_pkg::t_in_item it);
        dcrc_pkg::t_out_item r;
        logic                prev_ie;
        logic                irq;
        r   = '0;
        irq = 1'b0;
        if (it.kind == dcrc_pkg::KIND_READ) begin
            case (it.reg_select)
                dcrc_pkg::REG_CSR: r.read_data = st_csr | dcrc_pkg::CSR_DRIVE_RDY;
                dcrc_pkg::REG_BA:  r.read_data = st_ba;
                dcrc_pkg::REG_DA:  r.read_data = st_da;
                default: begin
                    // header words shift into MP on each read
                    r.read_data = st_mp;
                    if (hdr_count != 0) begin
                        st_mp        = hdr_words[0];
                        hdr_words[0] = hdr_words[1];
                        hdr_count    = hdr_count - 2'd1;
                    end
                end
            endcase
        end else begin
            case (it.reg_select)
                dcrc_pkg::REG_CSR: begin
                    prev_ie = st_ie;
                    st_csr  = it.write_data & dcrc_pkg::CSR_WRITE_MASK;
                    st_ie   = it.write_data[6];
                    if (!it.write_data[7])
                        run_disk_command(r, irq);
                    else if (!prev_ie && st_ie)
                        irq = 1'b1;
                    st_csr        = st_csr | dcrc_pkg::CSR_CTRL_RDY;
                    r.irq_request = irq;
                end
                dcrc_pkg::REG_BA:  st_ba = it.write_data & dcrc_pkg::BA_MASK;
                dcrc_pkg::REG_DA:  st_da = it.write_data;
                default: st_mp = it.write_data;
            endcase
        end
        return r;
    endfunction

    // Sender: presents queued items, predicts on acceptance
    int unsigned send_gap = 0;

    always @(posedge i_clk) begin : feed_bus
        logic               nvalid;
        dcrc_pkg::t_in_item nitem;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nvalid = in_valid;
            nitem  = in_item;
            if (in_valid && !o_in_stall)
                bus_replies_due.push_back(predict_bus_access(in_item));
            if (!in_valid || !o_in_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    nvalid = 1'b0;
                end else if (send_idle_on && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 9);
                    nvalid   = 1'b0;
                end else if (bus_access_queue.size() != 0) begin
                    nitem  = bus_access_queue.pop_front();
                    nvalid = 1'b1;
                end else begin
                    nvalid = 1'b0;
                end
                in_valid <= nvalid;
                in_item  <= nitem;
            end
        end
    end

    // Receiver: random stall bursts, checks each accepted reply
    int unsigned rcv_gap = 0;

    always @(posedge i_clk) begin : check_replies
        dcrc_pkg::t_out_item exp;
        logic                bad;
        logic                nstall;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (bus_replies_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected reply %h at %0t", o_out_item, $realtime);
                end else begin
                    exp = bus_replies_due.pop_front();
                    bad = (o_out_item.read_data      !== exp.read_data)
                       || (o_out_item.irq_request    !== exp.irq_request)
                       || (o_out_item.transfer_valid !== exp.transfer_valid)
                       || (o_out_item.transfer_write !== exp.transfer_write)
                       || (o_out_item.disk_block     !== exp.disk_block)
                       || (o_out_item.memory_address !== exp.memory_address)
                       || (o_out_item.transfer_bytes !== exp.transfer_bytes);
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("ERROR: reply mismatch at %0t", $realtime);
                            $display("  exp rd=%h irq=%b xv=%b xw=%b blk=%h ma=%h bytes=%h",
                                     exp.read_data, exp.irq_request, exp.transfer_valid,
                                     exp.transfer_write, exp.disk_block,
                                     exp.memory_address, exp.transfer_bytes);
                            $display("  got rd=%h irq=%b xv=%b xw=%b blk=%h ma=%h bytes=%h",
                                     o_out_item.read_data, o_out_item.irq_request,
                                     o_out_item.transfer_valid, o_out_item.transfer_write,
                                     o_out_item.disk_block, o_out_item.memory_address,
                                     o_out_item.transfer_bytes);
                        end
                    end
                end
            end
            if (rcv_gap != 0) begin
                rcv_gap--;
                nstall = 1'b1;
            end else if (rcv_idle_on && $urandom_range(0, 5) == 0) begin
                rcv_gap = $urandom_range(0, 9);
                nstall  = 1'b1;
            end else begin
                nstall = 1'b0;
            end
            out_stall <= nstall;
        end
    end

    task automatic queue_access(input dcrc_pkg::t_kind k, input dcrc_pkg::t_reg_sel s,
                                input logic [15:0] d);
        dcrc_pkg::t_in_item it;
        it.kind       = k;
        it.reg_select = s;
        it.write_data = d;
        bus_access_queue.push_back(it);
        queued_total++;
    endtask

    function automatic logic [15:0] csr_word(input logic [2:0] cmd, input logic ie,
                                             input logic hold);
        logic [15:0] noise;
        noise = 16'($urandom);
        return (noise & ~CSR_CODE_BITS) | {12'b0, cmd, 1'b0} | {9'b0, hold, ie, 6'b0};
    endfunction

    // Track and sector, sector biased toward the track end
    function automatic logic [15:0] disk_addr_word();
        logic [9:0] trk;
        logic [5:0] sec;
        int unsigned roll;
        trk  = 10'($urandom_range(0, 1023));
        roll = $urandom_range(0, 9);
        if (roll < 6)
            sec = 6'($urandom_range(0, 39));
        else if (roll == 6)
            sec = 6'd40;
        else if (roll == 7)
            sec = 6'($urandom_range(41, 63));
        else
            sec = 6'($urandom_range(30, 39));
        return {trk, sec};
    endfunction

    // Negated word count, mostly small
    function automatic logic [15:0] word_count_word();
        logic [15:0] words;
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            words = 16'($urandom_range(0, 300));
        else if (roll < 8)
            words = 16'($urandom_range(0, 5200));
        else if (roll == 8)
            words = 16'h0;
        else
            words = 16'($urandom);
        return 16'h0 - words;
    endfunction

    // Mostly setup-then-command sequences, plus noise accesses
    task automatic queue_random_traffic(input int unsigned n);
        int unsigned target;
        int unsigned roll;
        int unsigned nreads;
        logic [2:0]  cmd;
        target = queued_total + n;
        while (queued_total < target) begin
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                cmd = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 2) == 0)
                    queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_BA, 16'($urandom));
                if (cmd == dcrc_pkg::CMD_SEEK)
                    queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_DA, 16'($urandom));
                else
                    queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_DA, disk_addr_word());
                if ($urandom_range(0, 3) != 0)
                    queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_MP, word_count_word());
                queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR,
                             csr_word(cmd, 1'($urandom_range(0, 1)),
                                      $urandom_range(0, 7) == 0));
                nreads = $urandom_range(0, 3);
                repeat (nreads) begin
                    if (cmd == dcrc_pkg::CMD_READ_HEADER)
                        queue_access(dcrc_pkg::KIND_READ, dcrc_pkg::REG_MP, 16'($urandom));
                    else
                        queue_access(dcrc_pkg::KIND_READ,
                                     dcrc_pkg::t_reg_sel'($urandom_range(0, 3)),
                                     16'($urandom));
                end
            end else if (roll < 9) begin
                queue_access(dcrc_pkg::t_kind'($urandom_range(0, 1)),
                             dcrc_pkg::t_reg_sel'($urandom_range(0, 3)),
                             16'($urandom));
            end else begin
                queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR,
                             csr_word(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b1));
            end
        end
    endtask

    // Sampled at the falling edge to stay clear of the sender's updates
    task automatic wait_for_quiet();
        do @(negedge i_clk);
        while (bus_access_queue.size() != 0 || in_valid || bus_replies_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of image_loaded, then read it back
    task automatic set_image_loaded(input logic v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_IMAGE_LOADED;
        pwdata  <= {31'b0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_image = v;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {31'b0, v}) begin
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR: image_loaded readback exp=%h got=%h", {31'b0, v}, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_image_loaded(1'b1);

        // Directed: reset values, command codes, track-end and seek limits
        queue_access(dcrc_pkg::KIND_READ,  dcrc_pkg::REG_CSR, 16'h0000);
        queue_access(dcrc_pkg::KIND_READ,  dcrc_pkg::REG_MP,  16'hFFFF);
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_BA,  16'hFFFF);
        queue_access(dcrc_pkg::KIND_READ,  dcrc_pkg::REG_BA,  16'h0000);
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_DA,  16'h003F);
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_MP,  16'hFFFF);
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR,
                     {8'h0, 1'b0, 1'b1, 2'b0, dcrc_pkg::CMD_READ, 1'b0});
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_DA,  16'hFFE7);
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_MP,  16'hFC18);
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR,
                     {8'h0, 1'b0, 1'b1, 2'b0, dcrc_pkg::CMD_WRITE, 1'b0});
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_MP,  16'h0000);
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR,
                     {8'h0, 1'b0, 1'b0, 2'b0, dcrc_pkg::CMD_READ, 1'b0});
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_DA,  16'hFF94);
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR,
                     {8'h0, 1'b0, 1'b1, 2'b0, dcrc_pkg::CMD_SEEK, 1'b0});
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_DA,  16'h0080);
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR,
                     {8'h0, 1'b0, 1'b1, 2'b0, dcrc_pkg::CMD_SEEK, 1'b0});
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR,
                     {8'h0, 1'b0, 1'b1, 2'b0, dcrc_pkg::CMD_READ_HEADER, 1'b0});
        repeat (3) queue_access(dcrc_pkg::KIND_READ, dcrc_pkg::REG_MP, 16'h0000);
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_DA,  16'h0008);
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR,
                     {8'h0, 1'b0, 1'b1, 2'b0, dcrc_pkg::CMD_GET_STATUS, 1'b0});
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR,
                     {8'h0, 1'b0, 1'b0, 2'b0, dcrc_pkg::CMD_NOP, 1'b0});
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR,
                     {8'h0, 1'b0, 1'b1, 2'b0, CMD_SPARE_LO, 1'b0});
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR,
                     {8'h0, 1'b0, 1'b0, 2'b0, CMD_SPARE_HI, 1'b0});
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR, 16'h00C0);
        queue_access(dcrc_pkg::KIND_WRITE, dcrc_pkg::REG_CSR, 16'hFFFF);
        queue_access(dcrc_pkg::KIND_READ,  dcrc_pkg::REG_CSR, 16'h0000);
        queue_access(dcrc_pkg::KIND_READ,  dcrc_pkg::REG_DA,  16'h0000);
        wait_for_quiet();

        // Random phases; the image toggles and the last phase runs at full rate
        for (int p = 0; p < 5; p++) begin
            set_image_loaded(p != 0 && p != 2);
            send_idle_on = (p == 0 || p == 1 || p == 3);
            rcv_idle_on  = (p == 0 || p == 2 || p == 3);
            queue_random_traffic(PHASE_ITEMS);
            wait_for_quiet();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dcrc_pkg.sv
hw/rtl/dcrc_cfg.sv
hw/rtl/dcrc_xfer.sv
hw/rtl/dcrc_core.sv
hw/rtl/disk_cartridge_register_controller.sv
hw/rtl/dcrc_checker.sv
tb/tb_disk_cartridge_register_controller.sv
